@@ rtl/plus_minus_binary_gcd_126_core_macros.svh @@
// ----------------------------------------------------------------------------
// plus_minus_binary_gcd_126_core_macros.svh
// Assertion macros shared by the gcd core RTL.
// ----------------------------------------------------------------------------
`ifndef PLUS_MINUS_BINARY_GCD_126_CORE_MACROS_SVH
`define PLUS_MINUS_BINARY_GCD_126_CORE_MACROS_SVH

// Same-cycle implication, checked on clk, idle in reset.
`define PMGCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, idle in reset.
`define PMGCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pmgcd_pkg.sv @@
// ----------------------------------------------------------------------------
// pmgcd_pkg
// Widths, register addresses and shared types of the plus-minus gcd core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pmgcd_pkg;

  localparam int WORD_W           = 128;  // signed working values
  localparam int FIELD_W          = 126;  // value, modulus and result width
  localparam int LOW_W            = 64;
  localparam int HIGH_W           = 62;
  localparam int MODULUS_BITS_DEF = 126;
  localparam int SHIFT_STEP       = 8;    // max shift per cycle
  localparam int SHAMT_W          = 4;
  localparam int REG_ADDR_W       = 4;
  localparam int REG_DATA_W       = 64;

  // paddr[3] selects the register (byte addresses 0 and 8)
  localparam logic REG_SEL_MODULUS_LOW  = 1'b0;
  localparam logic REG_SEL_MODULUS_HIGH = 1'b1;

  typedef struct packed {
    logic src_b;     // primary operand is b (else a)
    logic abs_mode;  // magnitude of primary operand instead of plus/minus
  } alu_ctl_t;

  typedef struct packed {
    logic x_zero;
    logic x_odd;
  } alu_stat_t;

endpackage

@@ rtl/pmgcd_alu.sv @@
// ----------------------------------------------------------------------------
// pmgcd_alu
// Shared 128-bit unit: plus/minus add, magnitude, odd-making shift step
// and zero/odd status of the selected operand.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmgcd_alu (
  input  logic signed [pmgcd_pkg::WORD_W-1:0] a,
  input  logic signed [pmgcd_pkg::WORD_W-1:0] b,
  input  pmgcd_pkg::alu_ctl_t                 ctl,
  output logic signed [pmgcd_pkg::WORD_W-1:0] result,
  output logic signed [pmgcd_pkg::WORD_W-1:0] shifted,
  output pmgcd_pkg::alu_stat_t                stat
);

  logic signed [pmgcd_pkg::WORD_W-1:0] x;
  logic signed [pmgcd_pkg::WORD_W-1:0] y;
  logic        [pmgcd_pkg::WORD_W-1:0] opl;
  logic        [pmgcd_pkg::WORD_W-1:0] opr;
  logic        [pmgcd_pkg::WORD_W-1:0] sum;
  logic                                sub;
  logic        [pmgcd_pkg::SHAMT_W-1:0] shamt;

  assign x = ctl.src_b ? b : a;
  assign y = ctl.src_b ? a : b;

  // x + y when bit 1 differs, else x - y; magnitude uses 0 - x
  assign sub = ctl.abs_mode | ~(x[1] ^ y[1]);
  assign opl = ctl.abs_mode ? '0 : x;
  assign opr = ctl.abs_mode ? x : y;
  assign sum = opl + (sub ? ~opr : opr) + pmgcd_pkg::WORD_W'(sub);

  assign result = (ctl.abs_mode && !x[pmgcd_pkg::WORD_W-1]) ? x : sum;

  // Trailing zeros of the low byte, capped at a full step
  always_comb begin
    shamt = pmgcd_pkg::SHAMT_W'(pmgcd_pkg::SHIFT_STEP);
    for (int i = pmgcd_pkg::SHIFT_STEP - 1; i >= 0; i--) begin
      if (x[i]) shamt = pmgcd_pkg::SHAMT_W'(i);
    end
  end

  assign shifted     = x >>> shamt;
  assign stat.x_zero = (x == '0);
  assign stat.x_odd  = x[0];

endmodule

@@ rtl/plus_minus_binary_gcd_126_core.sv @@
// Sequence: after accept, each pass checks a, shifts a odd in steps of up to 8
//   bits, forms b +/- a, checks b, shifts b odd and forms a +/- b; a zero check
//   ends in the magnitude step, and passes are capped at 2*MODULUS_BITS+4.
// Flow: one request at a time; no new value is accepted until the result is
//   taken, and the shared 128-bit adder/shifter serves every step in turn.
// Reset (rst, synchronous): sequencer idle, modulus = 1.
// ----------------------------------------------------------------------------
// plus_minus_binary_gcd_126_core
// Gcd of a residue value and a configured odd modulus by the plus-minus
// binary method, run on one shared arithmetic unit under a small sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "plus_minus_binary_gcd_126_core_macros.svh"

module plus_minus_binary_gcd_126_core #(
  parameter int MODULUS_BITS = pmgcd_pkg::MODULUS_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input stream; s_tdata fields low to high: value_low[63:0],
  // value_high[125:64], zero pad[127:126]
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [pmgcd_pkg::WORD_W-1:0]         s_tdata,
  // Result stream; m_tdata fields low to high: divisor_low[63:0],
  // divisor_high[125:64], zero pad[127:126]
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [pmgcd_pkg::WORD_W-1:0]         m_tdata,
  // Configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pmgcd_pkg::REG_ADDR_W-1:0]     paddr,
  input  logic [pmgcd_pkg::REG_DATA_W-1:0]     pwdata,
  output logic [pmgcd_pkg::REG_DATA_W-1:0]     prdata,
  output logic                                 pready
);

  localparam int MAX_PASSES = 2 * MODULUS_BITS + 4;
  localparam int PASS_W     = $clog2(MAX_PASSES + 1);
  localparam logic [PASS_W-1:0] PASS_LIMIT = PASS_W'(MAX_PASSES);
  localparam logic [pmgcd_pkg::FIELD_W-1:0] TRUNC_MASK =
    {pmgcd_pkg::FIELD_W{1'b1}} >> (pmgcd_pkg::FIELD_W - MODULUS_BITS);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CHK_A = 9'b000000010,  // a zero -> |b|; pass limit -> zero result
    ST_ODD_A = 9'b000000100,  // shift a until odd
    ST_PM_B  = 9'b000001000,  // b = b +/- a
    ST_CHK_B = 9'b000010000,  // b zero -> |a|
    ST_ODD_B = 9'b000100000,  // shift b until odd
    ST_PM_A  = 9'b001000000,  // a = a +/- b, count the pass
    ST_ABS   = 9'b010000000,  // magnitude into the result register
    ST_OUT   = 9'b100000000   // hold result until taken
  } state_t;

  state_t state;
  state_t state_next;

  logic [pmgcd_pkg::LOW_W-1:0]  modulus_low;
  logic [pmgcd_pkg::HIGH_W-1:0] modulus_high;

  logic signed [pmgcd_pkg::WORD_W-1:0] a;
  logic signed [pmgcd_pkg::WORD_W-1:0] b;
  logic [PASS_W-1:0]                   pass;
  logic                                res_b;  // magnitude taken from b
  logic [pmgcd_pkg::FIELD_W-1:0]       divisor;

  pmgcd_pkg::alu_ctl_t                 ctl;
  pmgcd_pkg::alu_stat_t                stat;
  logic signed [pmgcd_pkg::WORD_W-1:0] alu_result;
  logic signed [pmgcd_pkg::WORD_W-1:0] alu_shifted;

  logic [pmgcd_pkg::FIELD_W-1:0] value_trunc;
  logic [pmgcd_pkg::FIELD_W-1:0] modulus_trunc;
  logic                          in_fire;
  logic                          cfg_write;

  // ---------------------------------------------------------------------------
  // Configuration registers: paddr[3] picks the register, always ready
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_low  <= pmgcd_pkg::LOW_W'(1);
      modulus_high <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3])
        pmgcd_pkg::REG_SEL_MODULUS_LOW:  modulus_low  <= pwdata;
        pmgcd_pkg::REG_SEL_MODULUS_HIGH: modulus_high <= pwdata[pmgcd_pkg::HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      pmgcd_pkg::REG_SEL_MODULUS_LOW:  prdata = modulus_low;
      pmgcd_pkg::REG_SEL_MODULUS_HIGH: prdata = pmgcd_pkg::REG_DATA_W'(modulus_high);
      default:                         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared arithmetic unit: operand choice follows the sequencer state
  // ---------------------------------------------------------------------------
  always_comb begin
    ctl.abs_mode = (state == ST_ABS);
    unique case (state)
      ST_PM_B, ST_CHK_B, ST_ODD_B: ctl.src_b = 1'b1;
      ST_ABS:                      ctl.src_b = res_b;
      default:                     ctl.src_b = 1'b0;
    endcase
  end

  pmgcd_alu u_alu (
    .a       (a),
    .b       (b),
    .ctl     (ctl),
    .result  (alu_result),
    .shifted (alu_shifted),
    .stat    (stat)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign s_tready      = (state == ST_IDLE);
  assign m_tvalid      = (state == ST_OUT);
  assign in_fire       = s_tvalid & s_tready;
  assign value_trunc   = s_tdata[pmgcd_pkg::FIELD_W-1:0] & TRUNC_MASK;
  assign modulus_trunc = {modulus_high, modulus_low} & TRUNC_MASK;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_fire) state_next = ST_CHK_A;
      ST_CHK_A: begin
        if (stat.x_zero)             state_next = ST_ABS;
        else if (pass == PASS_LIMIT) state_next = ST_OUT;
        else                         state_next = ST_ODD_A;
      end
      ST_ODD_A: if (stat.x_odd) state_next = ST_PM_B;
      ST_PM_B:  state_next = ST_CHK_B;
      ST_CHK_B: state_next = stat.x_zero ? ST_ABS : ST_ODD_B;
      ST_ODD_B: if (stat.x_odd) state_next = ST_PM_A;
      ST_PM_A:  state_next = ST_CHK_A;
      ST_ABS:   state_next = ST_OUT;
      ST_OUT:   if (m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers: load on accept, update in the working states
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          a    <= {2'b00, value_trunc};
          b    <= {2'b00, modulus_trunc};
          pass <= '0;
        end
      end
      ST_CHK_A: begin
        res_b <= 1'b1;
        // pass limit reached with a nonzero: result is zero
        if (!stat.x_zero && pass == PASS_LIMIT) divisor <= '0;
      end
      ST_ODD_A: if (!stat.x_odd) a <= alu_shifted;
      ST_PM_B:  b <= alu_result;
      ST_CHK_B: res_b <= 1'b0;
      ST_ODD_B: if (!stat.x_odd) b <= alu_shifted;
      ST_PM_A: begin
        a    <= alu_result;
        pass <= pass + PASS_W'(1);
      end
      ST_ABS:   divisor <= alu_result[pmgcd_pkg::FIELD_W-1:0];
      default: ;
    endcase
  end

  assign m_tdata = {2'b00, divisor};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PMGCD_ASSERT_IMP(a_odd_nonzero, (state == ST_ODD_A || state == ST_ODD_B), !stat.x_zero, "make-odd on zero operand")
  `PMGCD_ASSERT_IMP(a_pass_bound, 1'b1, pass <= PASS_LIMIT || state == ST_IDLE, "pass count beyond limit")
  `PMGCD_ASSERT_NEXT(a_busy_after_accept, in_fire, !s_tready, "ready right after accept")
  `PMGCD_ASSERT_IMP(a_no_overlap, m_tvalid, !s_tready, "accepting while a result waits")

endmodule
